// ----- hw/rtl/ci32_pkg.sv -----
// Package for the checked 32-bit integer ALU: payload structs, operation codes,
// the classified-item type passed from front to back, and constants.
// No dependencies.
package ci32_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_PLUS  = 4'd1,
        OP_SUB   = 4'd2,
        OP_MINUS = 4'd3,
        OP_MUL   = 4'd4,
        OP_TIMES = 4'd5,
        OP_DIV   = 4'd6,
        OP_REM   = 4'd7,
        OP_EQ    = 4'd8,
        OP_GT    = 4'd9,
        OP_AND   = 4'd10,
        OP_OR    = 4'd11,
        OP_XOR   = 4'd12,
        OP_NOT   = 4'd13,
        OP_LSH   = 4'd14,
        OP_RSH   = 4'd15
    } t_op;

    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_word;
        logic        error_flag;
    } t_out_item;

    // Item after classification. Simple operations are finished in the front;
    // multiply and divide carry magnitudes and sign information to the back.
    typedef struct packed {
        logic        is_mul;
        logic        is_div;
        logic        checked;
        logic        want_rem;
        logic        neg_res;
        logic        early_err;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] simple;
    } t_work;

endpackage

// ----- hw/rtl/ci32_front.sv -----
// Front part of the ALU: accepts items, finishes simple operations and
// prepares multiply and divide work. Depends on ci32_pkg.
module ci32_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ci32_pkg::t_in_item  i_in_data,
    output logic                o_valid,
    input  logic                i_stall,
    output ci32_pkg::t_work     o_work
);

    logic              r_valid;
    ci32_pkg::t_work   r_work;
    ci32_pkg::t_work   n_work;
    logic [31:0]       a, b, sum, dif;
    logic              sa, sb, big;

    assign o_in_stall = r_valid && i_stall;
    assign o_valid    = r_valid;
    assign o_work     = r_work;

    always_comb begin
        a   = i_in_data.operand_a;
        b   = i_in_data.operand_b;
        sa  = a[31];
        sb  = b[31];
        sum = a + b;
        dif = a - b;
        big = |b[31:5];
        n_work = '0;
        n_work.mag_a = sa ? (~a + 32'd1) : a;
        n_work.mag_b = sb ? (~b + 32'd1) : b;
        case (ci32_pkg::t_op'(i_in_data.operation))
            ci32_pkg::OP_ADD: begin
                n_work.early_err = (sa == sb) && (sum[31] != sa);
                n_work.simple = sum;
            end
            ci32_pkg::OP_PLUS:  n_work.simple = sum;
            ci32_pkg::OP_SUB: begin
                n_work.early_err = (sa != sb) && (dif[31] != sa);
                n_work.simple = dif;
            end
            ci32_pkg::OP_MINUS: n_work.simple = dif;
            ci32_pkg::OP_MUL: begin
                n_work.is_mul  = 1'b1;
                n_work.checked = 1'b1;
                n_work.neg_res = sa ^ sb;
            end
            ci32_pkg::OP_TIMES: begin
                // Wrapping product: low word equals the unsigned product.
                n_work.is_mul = 1'b1;
                n_work.mag_a  = a;
                n_work.mag_b  = b;
            end
            ci32_pkg::OP_DIV: begin
                n_work.is_div    = 1'b1;
                n_work.neg_res   = sa ^ sb;
                n_work.early_err = (b == 32'd0) ||
                                   (a == 32'h8000_0000 && b == 32'hFFFF_FFFF);
            end
            ci32_pkg::OP_REM: begin
                n_work.is_div    = 1'b1;
                n_work.want_rem  = 1'b1;
                n_work.neg_res   = sa;
                n_work.early_err = (b == 32'd0);
            end
            ci32_pkg::OP_EQ:  n_work.simple = {31'd0, a == b};
            ci32_pkg::OP_GT:  n_work.simple = {31'd0, $signed(a) > $signed(b)};
            ci32_pkg::OP_AND: n_work.simple = a & b;
            ci32_pkg::OP_OR:  n_work.simple = a | b;
            ci32_pkg::OP_XOR: n_work.simple = a ^ b;
            ci32_pkg::OP_NOT: n_work.simple = ~a;
            ci32_pkg::OP_LSH: n_work.simple = big ? 32'd0 : (a << b[4:0]);
            ci32_pkg::OP_RSH: n_work.simple = big ? 32'd0 : (a >> b[4:0]);
            default:          n_work.simple = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_work <= n_work;
        end
    end

endmodule

// ----- hw/rtl/ci32_queue.sv -----
// Short FIFO between the front and the back of the ALU.
// Depends on ci32_pkg.
module ci32_queue #(
    parameter int unsigned Depth = ci32_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ci32_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ci32_pkg::t_work o_data
);

    localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

    ci32_pkg::t_work     r_mem [Depth];
    logic [Aw-1:0]       r_wp, r_rp;
    logic [Aw:0]         r_cnt;
    logic                push, pop;

    assign o_stall = (r_cnt == Aw'(0) + (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Aw'(Depth - 1)) ? '0 : r_wp + Aw'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == Aw'(Depth - 1)) ? '0 : r_rp + Aw'(1);
            end
            r_cnt <= r_cnt + (Aw+1)'(push) - (Aw+1)'(pop);
        end
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/ci32_back.sv -----
// Back part of the ALU: pipelined 32x32 multiplier and a pipelined
// radix-2 divider, one quotient bit per stage. Depends on ci32_pkg.
module ci32_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ci32_pkg::t_work     i_work,
    output logic                o_valid,
    input  logic                i_stall,
    output ci32_pkg::t_out_item o_data
);

    localparam int unsigned W = ci32_pkg::WordWidth;
    localparam int unsigned Stages = W + 2;

    // Pipeline enable: whole pipe advances unless the output is held.
    logic                 adv;
    logic                 r_v   [Stages];
    ci32_pkg::t_work      r_w   [Stages];
    logic [W-1:0]         r_q   [Stages];
    logic [W-1:0]         r_r   [Stages];
    logic [2*W-1:0]       r_p;
    logic [W-1:0]         r_res;
    logic                 r_err;
    logic                 r_ovalid;
    logic [W:0]           trial [W];
    logic [W-1:0]         rem_sh [W];

    assign adv     = !(r_ovalid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_ovalid;
    assign o_data  = '{result_word: r_res, error_flag: r_err};

    // Divider stage k handles quotient bit W-1-k.
    always_comb begin
        for (int k = 0; k < W; k++) begin
            rem_sh[k] = {r_r[k][W-2:0], r_q[k][W-1]};
            trial[k]  = {1'b0, rem_sh[k]} - {1'b0, r_w[k].mag_b};
            if (r_r[k][W-1]) begin
                trial[k][W] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Stages; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < Stages; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ovalid <= r_v[Stages-1];
        end
        if (adv) begin
            r_w[0] <= i_work;
            r_q[0] <= i_work.mag_a;
            r_r[0] <= '0;
            for (int k = 1; k <= W; k++) begin
                r_w[k] <= r_w[k-1];
                if (!trial[k-1][W]) begin
                    r_r[k] <= trial[k-1][W-1:0];
                    r_q[k] <= {r_q[k-1][W-2:0], 1'b1};
                end else begin
                    r_r[k] <= rem_sh[k-1];
                    r_q[k] <= {r_q[k-1][W-2:0], 1'b0};
                end
            end
            // Multiplier: product registered, overflow checked next stage.
            r_w[W+1] <= r_w[W];
            r_q[W+1] <= r_q[W];
            r_r[W+1] <= r_r[W];
            r_p      <= r_w[W].mag_a * r_w[W].mag_b;
            r_res    <= r_w[W+1].simple;
            r_err    <= r_w[W+1].early_err;
            if (r_w[W+1].early_err) begin
                r_res <= '0;
            end else if (r_w[W+1].is_mul) begin
                if (!r_w[W+1].checked) begin
                    r_res <= r_p[W-1:0];
                end else if (r_p[2*W-1:W] != '0 || (r_p[W-1] &&
                             !(r_w[W+1].neg_res && r_p[W-1:0] == {1'b1, {(W-1){1'b0}}}))) begin
                    r_res <= '0;
                    r_err <= 1'b1;
                end else begin
                    r_res <= r_w[W+1].neg_res ? (~r_p[W-1:0] + W'(1)) : r_p[W-1:0];
                end
            end else if (r_w[W+1].is_div) begin
                if (r_w[W+1].want_rem) begin
                    r_res <= r_w[W+1].neg_res ? (~r_r[W+1] + W'(1)) : r_r[W+1];
                end else begin
                    r_res <= r_w[W+1].neg_res ? (~r_q[W+1] + W'(1)) : r_q[W+1];
                end
            end
        end
    end

endmodule

// ----- hw/rtl/checked_int32_alu.sv -----
// Top level of the checked 32-bit integer ALU: front classifier, queue and
// pipelined back end. Depends on ci32_pkg, ci32_front, ci32_queue, ci32_back.
//
//   Channel | Valid      | Stall       | Payload
//   input   | i_in_valid | o_in_stall  | i_in_data  (ci32_pkg::t_in_item)
//   output  | o_out_valid| i_out_stall | o_out_data (ci32_pkg::t_out_item)
//
// One item is accepted per cycle while o_in_stall is low. With an empty queue
// the result, once the item is accepted into the front register, passes the
// queue, the back's load stage, a 32-stage divider line that every item
// travels, one multiplier product stage and one output register.
// Reset (synchronous, active low) empties every stage and the queue.
// A stall at the output freezes the back pipeline; the queue then absorbs
// up to its depth before the input is stalled.
module checked_int32_alu #(
    parameter int unsigned QueueDepth = ci32_pkg::QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ci32_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ci32_pkg::t_out_item o_out_data
);

    // Front to queue.
    logic            f_valid, f_stall;
    ci32_pkg::t_work f_work;
    // Queue to back.
    logic            q_valid, q_stall;
    ci32_pkg::t_work q_work;

    ci32_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_valid    (f_valid),
        .i_stall    (f_stall),
        .o_work     (f_work)
    );

    ci32_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_data  (f_work),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_data  (q_work)
    );

    // The back accepts whenever its pipeline advances; a queue item is
    // taken only then.
    ci32_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_stall (q_stall),
        .i_work  (q_work),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
